### sv/fxr_pkg.sv
// Shared types and constants for the fixup record translator.
package fxr_pkg;

	localparam int PAGE_SHIFT_DEF  = 12;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int BYTE_W   = 8;
	localparam int PAGE_W   = 20;
	localparam int TYPE_W   = 4;
	localparam int WORD_W   = 16;
	localparam int OFFSET_W = 32;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 80;

	localparam logic [WORD_W-1:0] FLAGS_UNSUPPORTED = 16'h0720;
	localparam int                OBJ16_BIT         = 14;
	localparam int                OFF32_BIT         = 12;
	localparam logic [TYPE_W-1:0] TYPE_NO_OFFSET    = 4'd2;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FLAGS  = 2'd1,
		ST_OBJECT = 2'd2,
		ST_TRUNC  = 2'd3
	} fxr_status_t;

	typedef enum logic [3:0] {
		PH_HDR0 = 4'd0,
		PH_HDR1 = 4'd1,
		PH_SRC0 = 4'd2,
		PH_SRC1 = 4'd3,
		PH_OBJ0 = 4'd4,
		PH_OBJ1 = 4'd5,
		PH_OFF0 = 4'd6,
		PH_OFF1 = 4'd7,
		PH_OFF2 = 4'd8,
		PH_OFF3 = 4'd9
	} fxr_phase_t;

	typedef struct packed {
		fxr_status_t         status;
		logic [TYPE_W-1:0]   ftype;
		logic [WORD_W-1:0]   src;
		logic [PAGE_W-1:0]   page;
		logic [BYTE_W-1:0]   obj;
		logic [OFFSET_W-1:0] toff;
	} fxr_rec_t;

endpackage

### sv/fxr_front.sv
// Byte parser that turns the fixup byte stream into finished record entries.
module fxr_front import fxr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [PAGE_W-1:0] page_index,
	input  logic              last_of_page,
	input  logic              q_full,
	output logic              push,
	output fxr_rec_t          rec
);

	fxr_phase_t          phase_q, phase_d;
	logic                discard_q, discard_d;
	logic [WORD_W-1:0]   hdr_q, hdr_d;
	logic [WORD_W-1:0]   src_q, src_d;
	logic [BYTE_W-1:0]   obj_q, obj_d;
	logic [OFFSET_W-1:0] off_q, off_d;
	logic                acc;
	logic                done;
	logic                obj_done;
	fxr_status_t         err;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			discard_q <= 1'b0;
			hdr_q     <= '0;
			src_q     <= '0;
			obj_q     <= '0;
			off_q     <= '0;
		end else begin
			phase_q   <= phase_d;
			discard_q <= discard_d;
			hdr_q     <= hdr_d;
			src_q     <= src_d;
			obj_q     <= obj_d;
			off_q     <= off_d;
		end
	end

	always_comb begin
		phase_d   = phase_q;
		discard_d = discard_q;
		hdr_d     = hdr_q;
		src_d     = src_q;
		obj_d     = obj_q;
		off_d     = off_q;
		err       = ST_OK;
		done      = 1'b0;
		obj_done  = 1'b0;
		if (acc && discard_q) begin
			if (last_of_page) begin
				discard_d = 1'b0;
				phase_d   = PH_HDR0;
			end
		end else if (acc) begin
			unique case (phase_q)
				PH_HDR0: begin
					hdr_d   = {8'h00, data_byte};
					phase_d = PH_HDR1;
				end
				PH_HDR1: begin
					hdr_d = {data_byte, hdr_q[7:0]};
					if (({data_byte, hdr_q[7:0]} & FLAGS_UNSUPPORTED) != '0) begin
						err = ST_FLAGS;
					end else begin
						phase_d = PH_SRC0;
					end
				end
				PH_SRC0: begin
					src_d   = {8'h00, data_byte};
					phase_d = PH_SRC1;
				end
				PH_SRC1: begin
					src_d   = {data_byte, src_q[7:0]};
					phase_d = PH_OBJ0;
				end
				PH_OBJ0: begin
					obj_d = data_byte;
					if (hdr_q[OBJ16_BIT]) begin
						phase_d = PH_OBJ1;
					end else begin
						obj_done = 1'b1;
					end
				end
				PH_OBJ1: begin
					if (data_byte != '0) begin
						err = ST_OBJECT;
					end else begin
						obj_done = 1'b1;
					end
				end
				PH_OFF0: begin
					off_d   = {24'h000000, data_byte};
					phase_d = PH_OFF1;
				end
				PH_OFF1: begin
					off_d = {16'h0000, data_byte, off_q[7:0]};
					if (hdr_q[OFF32_BIT]) begin
						phase_d = PH_OFF2;
					end else begin
						done = 1'b1;
					end
				end
				PH_OFF2: begin
					off_d   = {8'h00, data_byte, off_q[15:0]};
					phase_d = PH_OFF3;
				end
				PH_OFF3: begin
					off_d = {data_byte, off_q[23:0]};
					done  = 1'b1;
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase
			if (obj_done) begin
				off_d = '0;
				if (hdr_q[TYPE_W-1:0] == TYPE_NO_OFFSET) begin
					done = 1'b1;
				end else begin
					phase_d = PH_OFF0;
				end
			end
			if (err != ST_OK) begin
				phase_d   = PH_HDR0;
				discard_d = !last_of_page;
			end else if (done) begin
				phase_d = PH_HDR0;
			end else if (last_of_page) begin
				err     = ST_TRUNC;
				phase_d = PH_HDR0;
			end
		end
	end

	assign push = acc && !discard_q && (done || err != ST_OK);

	always_comb begin
		rec = '0;
		rec.status = err;
		if (err == ST_OK) begin
			rec.ftype = hdr_q[TYPE_W-1:0];
			rec.src   = src_q;
			rec.page  = page_index;
			rec.obj   = obj_d;
			rec.toff  = off_d;
		end
	end

endmodule

### sv/fxr_queue.sv
// Short register queue between the parser and the result stage.
module fxr_queue import fxr_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  fxr_rec_t push_rec,
	output logic     full,
	input  logic     pop,
	output logic     not_empty,
	output fxr_rec_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	fxr_rec_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_FULL);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop)
		else $error("Entry written into a full queue.");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("Entry taken from an empty queue.");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("Queue count did not follow a write.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("Queue count beyond its depth.");

endmodule

### sv/fxr_back.sv
// Result stage: relocates the source offset and holds the output item.
module fxr_back import fxr_pkg::*; #(
	parameter int PAGE_SHIFT = PAGE_SHIFT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_not_empty,
	input  fxr_rec_t                   q_head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [TYPE_W-1:0]          fixup_type,
	output logic signed [OFFSET_W-1:0] source_offset,
	output logic [BYTE_W-1:0]          target_object,
	output logic [OFFSET_W-1:0]        target_offset,
	output fxr_status_t                status
);

	logic                valid_q;
	logic [TYPE_W-1:0]   type_q;
	logic [OFFSET_W-1:0] src_q;
	logic [BYTE_W-1:0]   obj_q;
	logic [OFFSET_W-1:0] toff_q;
	fxr_status_t         status_q;
	logic [OFFSET_W-1:0] page_base;
	logic [OFFSET_W-1:0] src_ext;
	logic [OFFSET_W-1:0] src_sum;

	assign pop       = q_not_empty && (!valid_q || out_ready);
	assign page_base = OFFSET_W'(q_head.page) << PAGE_SHIFT;
	assign src_ext   = {{(OFFSET_W - WORD_W){q_head.src[WORD_W-1]}}, q_head.src};
	assign src_sum   = src_ext + page_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			type_q   <= q_head.ftype;
			src_q    <= (q_head.status == ST_OK) ? src_sum : '0;
			obj_q    <= q_head.obj;
			toff_q   <= q_head.toff;
			status_q <= q_head.status;
		end
	end

	assign out_valid     = valid_q;
	assign fixup_type    = type_q;
	assign source_offset = src_q;
	assign target_object = obj_q;
	assign target_offset = toff_q;
	assign status        = status_q;

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_q)
		else $error("Taken entry did not reach the output register.");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && status_q != ST_OK |-> src_q == '0 && type_q == '0 && toff_q == '0)
		else $error("Error item carries nonzero record fields.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |-> !pop)
		else $error("Output register overwritten while stalled.");

endmodule

### sv/fixup_record_translator.sv
// Top level of the fixup record translator: parser, queue and result stage.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata: data_byte, page_index; tlast: last_of_page
//   m_axis    out        tdata: fixup_type, source_offset, target_object, target_offset;
//                        tuser: status
//
// One byte is taken per cycle while the queue has room; the parser phase register
// carries the record state from byte to byte. The byte that finishes a record writes
// it into the queue, and from the queue it is loaded into the output register.
// A stall on the output fills the queue before the input is held.
// Reset clears the parser, the queue pointers and the output valid flag.
module fixup_record_translator import fxr_pkg::*; #(
	parameter int PAGE_SHIFT  = PAGE_SHIFT_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// data_byte [7:0], page_index [27:8], zero fill [31:28]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// fixup_type [3:0], source_offset [35:4], target_object [43:36],
	// target_offset [75:44], zero fill [79:76]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// status [1:0]
	output logic [1:0]            m_axis_tuser
);

	logic                       push;
	fxr_rec_t                   push_rec;
	logic                       q_full;
	logic                       pop;
	logic                       q_not_empty;
	fxr_rec_t                   q_head;
	logic [TYPE_W-1:0]          fixup_type;
	logic signed [OFFSET_W-1:0] source_offset;
	logic [BYTE_W-1:0]          target_object;
	logic [OFFSET_W-1:0]        target_offset;
	fxr_status_t                status;

	fxr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.data_byte    (s_axis_tdata[7:0]),
		.page_index   (s_axis_tdata[27:8]),
		.last_of_page (s_axis_tlast),
		.q_full       (q_full),
		.push         (push),
		.rec          (push_rec)
	);

	fxr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (push_rec),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	fxr_back #(
		.PAGE_SHIFT (PAGE_SHIFT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_not_empty   (q_not_empty),
		.q_head        (q_head),
		.pop           (pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.fixup_type    (fixup_type),
		.source_offset (source_offset),
		.target_object (target_object),
		.target_offset (target_offset),
		.status        (status)
	);

	assign m_axis_tdata = {4'h0, target_offset, target_object, source_offset, fixup_type};
	assign m_axis_tuser = status;

endmodule
